/* rtl/imu_tilt_pkg.sv */
// Shared constants and the CORDIC angle table for the tilt and gyro integrator.
// Depends on nothing; imu_tilt_atan, top and testbench use it by scoped names.
`timescale 1ns / 1ps

package imu_tilt_pkg;

	// 9.81 in Q16.16 scaled for 16384 LSB per g, result in 2^-8 m/s^2.
	localparam logic [23:0] ACCEL_K = 24'd642908;
	// pi/180/131*4096 in Q0.24.
	localparam logic [23:0] RATE_K = 24'd9155581;
	// Width of the calibration sample counter.
	localparam int CNT_W = 10;

	// atan(2^-i) in units of 2^-16 rad.
	function automatic logic [15:0] atan_entry(input logic [4:0] i);
		logic [15:0] v;
		unique case (i)
			5'd0:    v = 16'd51472;
			5'd1:    v = 16'd30386;
			5'd2:    v = 16'd16055;
			5'd3:    v = 16'd8150;
			5'd4:    v = 16'd4091;
			5'd5:    v = 16'd2047;
			5'd6:    v = 16'd1024;
			5'd7:    v = 16'd512;
			5'd8:    v = 16'd256;
			5'd9:    v = 16'd128;
			5'd10:   v = 16'd64;
			5'd11:   v = 16'd32;
			5'd12:   v = 16'd16;
			5'd13:   v = 16'd8;
			5'd14:   v = 16'd4;
			5'd15:   v = 16'd2;
			5'd16:   v = 16'd1;
			default: v = 16'd0;
		endcase
		return v;
	endfunction

endpackage

/* rtl/imu_tilt_smul.sv */
// Bit-serial unsigned shift-and-add multiplier, one multiplier bit per cycle.
// Depends on nothing.
`timescale 1ns / 1ps

module imu_tilt_smul #(
	parameter int WA = 16,
	parameter int WB = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WA-1:0]    a,
	input  logic [WB-1:0]    b,
	output logic [WA+WB-1:0] p,
	output logic             busy
);

	localparam int CW = $clog2(WB + 1);

	logic [WA+WB-1:0] a_q;
	logic [WA+WB-1:0] p_q;
	logic [WB-1:0]    b_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			a_q    <= '0;
			b_q    <= '0;
			p_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(WB);
			a_q    <= (WA+WB)'(a);
			b_q    <= b;
			p_q    <= '0;
		end else if (busy_q) begin
			if (b_q[0]) begin
				p_q <= p_q + a_q;
			end
			a_q   <= a_q << 1;
			b_q   <= b_q >> 1;
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign p    = p_q;
	assign busy = busy_q;

endmodule

/* rtl/imu_tilt_atan.sv */
// Roll and pitch unit: serial squares, a two-bits-per-cycle square root and
// one CORDIC vectoring step per cycle. Depends on imu_tilt_pkg and imu_tilt_smul.
`timescale 1ns / 1ps

module imu_tilt_atan #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [15:0] ax,
	input  logic signed [15:0] ay,
	input  logic signed [15:0] az,
	output logic signed [15:0] roll,
	output logic signed [15:0] pitch,
	output logic               busy
);

	typedef enum logic [5:0] {
		T_IDLE = 6'b000001,
		T_SQ   = 6'b000010,
		T_SQW  = 6'b000100,
		T_ROOT = 6'b001000,
		T_RINI = 6'b010000,
		T_ROT  = 6'b100000
	} tstate_t;

	tstate_t            state_q;
	logic signed [15:0] ax_q, ay_q, az_q;
	logic               pass_q, term_q;
	logic [31:0]        m2_q;
	logic [47:0]        rad_q;
	logic [25:0]        rem_q;
	logic [23:0]        root_q;
	logic signed [27:0] x_q, y_q;
	logic signed [19:0] z_q;
	logic [4:0]         it_q;
	logic signed [15:0] roll_q, pitch_q;
	logic               fin_q;

	logic signed [16:0] num;
	logic signed [15:0] a_sel, sq_in;
	logic [15:0]        sq_mag;
	logic               mul_start, mul_busy;
	logic [31:0]        mul_p, m2_n;
	logic [27:0]        rem_sh, trial, rem_dif;
	logic signed [27:0] xs, ys;
	logic signed [19:0] z_step;
	logic [19:0]        z_mag;
	logic [19:0]        z_rnd;
	logic [15:0]        res;

	assign num    = pass_q ? -{ax_q[15], ax_q} : {ay_q[15], ay_q};
	assign a_sel  = pass_q ? ay_q : ax_q;
	assign sq_in  = term_q ? az_q : a_sel;
	assign sq_mag = sq_in[15] ? 16'(-sq_in) : 16'(sq_in);
	assign mul_start = (state_q == T_SQ);
	assign m2_n   = m2_q + mul_p;

	assign rem_sh  = {rem_q, rad_q[47:46]};
	assign trial   = {2'b00, root_q, 2'b01};
	assign rem_dif = rem_sh - trial;

	assign xs     = x_q >>> it_q;
	assign ys     = y_q >>> it_q;
	assign z_step = 20'(imu_tilt_pkg::atan_entry(it_q));

	// Rounding of the angle from 2^-16 to 2^-13 rad, half away from zero.
	assign z_mag = z_q[19] ? 20'(-z_q) : 20'(z_q);
	assign z_rnd = (z_mag + 20'd4) >> 3;
	assign res   = z_q[19] ? 16'(-z_rnd[15:0]) : z_rnd[15:0];

	imu_tilt_smul #(.WA(16), .WB(16)) u_sq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (sq_mag),
		.b      (sq_mag),
		.p      (mul_p),
		.busy   (mul_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			ax_q <= '0; ay_q <= '0; az_q <= '0;
			pass_q <= 1'b0; term_q <= 1'b0;
			m2_q <= '0; rad_q <= '0; rem_q <= '0; root_q <= '0;
			x_q <= '0; y_q <= '0; z_q <= '0; it_q <= '0;
			roll_q <= '0; pitch_q <= '0; fin_q <= 1'b0;
		end else begin
			if (fin_q) begin
				fin_q <= 1'b0;
				if (pass_q) begin
					pitch_q <= res;
					state_q <= T_IDLE;
				end else begin
					roll_q  <= res;
					pass_q  <= 1'b1;
					term_q  <= 1'b0;
					m2_q    <= '0;
					state_q <= T_SQ;
				end
			end else begin
				unique case (state_q)
					T_IDLE: begin
						if (start) begin
							ax_q <= ax; ay_q <= ay; az_q <= az;
							pass_q  <= 1'b0;
							term_q  <= 1'b0;
							m2_q    <= '0;
							state_q <= T_SQ;
						end
					end
					T_SQ: begin
						state_q <= T_SQW;
					end
					T_SQW: begin
						if (!mul_busy) begin
							m2_q <= m2_n;
							if (!term_q) begin
								term_q  <= 1'b1;
								state_q <= T_SQ;
							end else begin
								rad_q   <= {m2_n, 16'd0};
								rem_q   <= '0;
								root_q  <= '0;
								it_q    <= '0;
								state_q <= T_ROOT;
							end
						end
					end
					T_ROOT: begin
						if (rem_sh >= trial) begin
							rem_q  <= rem_dif[25:0];
							root_q <= {root_q[22:0], 1'b1};
						end else begin
							rem_q  <= rem_sh[25:0];
							root_q <= {root_q[22:0], 1'b0};
						end
						rad_q <= rad_q << 2;
						it_q  <= it_q + 5'd1;
						if (it_q == 5'd23) begin
							state_q <= T_RINI;
						end
					end
					T_RINI: begin
						x_q  <= {4'd0, root_q};
						y_q  <= {{3{num[16]}}, num, 8'd0};
						z_q  <= '0;
						it_q <= '0;
						// A zero vector gives a tilt of zero.
						if (root_q == '0 && num == '0) begin
							fin_q <= 1'b1;
						end else begin
							state_q <= T_ROT;
						end
					end
					T_ROT: begin
						if (!y_q[27]) begin
							x_q <= x_q + ys;
							y_q <= y_q - xs;
							z_q <= z_q + z_step;
						end else begin
							x_q <= x_q - ys;
							y_q <= y_q + xs;
							z_q <= z_q - z_step;
						end
						it_q <= it_q + 5'd1;
						if (it_q == 5'(CORDIC_STEPS - 1)) begin
							fin_q <= 1'b1;
						end
					end
					default: state_q <= T_IDLE;
				endcase
			end
		end
	end

	assign roll  = roll_q;
	assign pitch = pitch_q;
	assign busy  = (state_q != T_IDLE) || fin_q;

endmodule

/* rtl/imu_tilt_gyro_integrator.sv */
// Top level of the tilt and gyro integrator: sequencer, calibration and rate path.
// Depends on imu_tilt_pkg, imu_tilt_smul and imu_tilt_atan.
`timescale 1ns / 1ps

// Channel  Direction  Handshake               Carries
// cfg      in         cfg_valid / cfg_ready   cfg_data: step_time, Q0.16 seconds
// in       in         in_valid  / in_ready    func, accel_raw_x/y/z, gyro_raw_x/y/z
// out      out        out_valid / out_ready   tilt, accelerations, rates, angles, mode
//
// One item is worked on at a time. A sample takes longer in calibrated mode than
// otherwise; its time is set by the bit-serial multipliers (one multiplier bit per
// cycle) and the root and CORDIC steps, one per cycle, in the tilt unit, which runs
// alongside the rate path. On the last calibration sample the three serial
// divisions, one quotient bit per cycle, outlast the tilt unit and lengthen the item.
// Reset is asynchronous and brings every register to its reset value at once.
// A result that is not taken holds the next item at its final step, and the item
// after that waits for its input transfer.

module imu_tilt_gyro_integrator #(
	parameter int CALIB_SAMPLES = 500,
	parameter int CORDIC_STEPS  = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               func,
	input  logic signed [15:0] accel_raw_x,
	input  logic signed [15:0] accel_raw_y,
	input  logic signed [15:0] accel_raw_z,
	input  logic signed [15:0] gyro_raw_x,
	input  logic signed [15:0] gyro_raw_y,
	input  logic signed [15:0] gyro_raw_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] roll_angle,
	output logic signed [15:0] pitch_angle,
	output logic signed [13:0] accel_x_si,
	output logic signed [13:0] accel_y_si,
	output logic signed [13:0] accel_z_si,
	output logic signed [16:0] rate_x,
	output logic signed [16:0] rate_y,
	output logic signed [16:0] rate_z,
	output logic signed [31:0] angle_x,
	output logic signed [31:0] angle_y,
	output logic signed [31:0] angle_z,
	output logic               calibrating
);

	// Width of the divisor, and the divisor itself, for the bias average.
	localparam int NW = $clog2(CALIB_SAMPLES + 1);
	localparam logic [NW-1:0] DIV_N    = NW'(CALIB_SAMPLES);
	localparam logic [33:0]   DIV_HALF = 34'(CALIB_SAMPLES / 2);
	localparam logic [imu_tilt_pkg::CNT_W-1:0] CNT_END =
		imu_tilt_pkg::CNT_W'(CALIB_SAMPLES);

	typedef enum logic [12:0] {
		S_IDLE = 13'b0000000000001,
		S_ACC  = 13'b0000000000010,
		S_ACCW = 13'b0000000000100,
		S_CAL  = 13'b0000000001000,
		S_DIVI = 13'b0000000010000,
		S_DIV  = 13'b0000000100000,
		S_DIVE = 13'b0000001000000,
		S_RD   = 13'b0000010000000,
		S_RDW  = 13'b0000100000000,
		S_RI   = 13'b0001000000000,
		S_RIW  = 13'b0010000000000,
		S_TW   = 13'b0100000000000,
		S_FIN  = 13'b1000000000000
	} state_t;

	state_t state_q;
	logic [1:0] idx_q;

	// The transferred item.
	logic               func_q;
	logic signed [15:0] acc_q [3];
	logic signed [15:0] gyr_q [3];

	// Block state.
	logic [15:0]                     step_q;
	logic                            mode_q;
	logic [imu_tilt_pkg::CNT_W-1:0] cnt_q;
	logic signed [24:0]              sum_q  [3];
	logic signed [23:0]              bias_q [3];
	logic signed [16:0]              rate_q [3];
	logic signed [31:0]              ang_q  [3];
	logic signed [13:0]              accsi_q [3];

	// Serial divider.
	logic [33:0]   dvd_q, quo_q;
	logic [NW-1:0] rem_q;
	logic [5:0]    dcnt_q;
	logic          dneg_q;

	// Result register.
	logic               ov_q;
	logic signed [15:0] o_roll_q, o_pitch_q;
	logic signed [13:0] o_acc_q  [3];
	logic signed [16:0] o_rate_q [3];
	logic signed [31:0] o_ang_q  [3];
	logic               o_cal_q;

	logic               tilt_start, tilt_busy;
	logic signed [15:0] tilt_roll, tilt_pitch;

	logic        mul_start, mul_busy;
	logic [24:0] mul_a;
	logic [23:0] mul_b;
	logic [48:0] mul_p;

	logic signed [15:0] acc_sel, gyr_sel;
	logic [15:0]        acc_mag;
	logic signed [23:0] bias_sel;
	logic signed [24:0] d_val, sum_sel;
	logic [24:0]        d_mag, s_mag;
	logic signed [16:0] r_sel;
	logic [16:0]        r_mag;
	logic [48:0]        p_acc, p_rt, p_inc;
	logic [13:0]        acc_q14;
	logic [16:0]        rt_q17;
	logic signed [16:0] rt_val;
	logic [25:0]        inc_mag;
	logic signed [33:0] ang_sum;
	logic signed [31:0] ang_new;
	logic signed [25:0] sum_n [3];
	logic signed [24:0] sum_sat [3];
	logic [imu_tilt_pkg::CNT_W-1:0] cnt_n;
	logic [NW:0]   rem_sh, rem_sub;
	logic [23:0]   q24;

	assign cfg_ready  = 1'b1;
	assign in_ready   = (state_q == S_IDLE);
	assign tilt_start = in_valid && in_ready;

	assign acc_sel  = acc_q[idx_q];
	assign acc_mag  = acc_sel[15] ? 16'(-acc_sel) : 16'(acc_sel);
	assign gyr_sel  = gyr_q[idx_q];
	assign bias_sel = bias_q[idx_q];
	// Difference of the raw rate, with 8 fraction bits, and the bias.
	assign d_val    = {gyr_sel[15], gyr_sel, 8'd0} - {bias_sel[23], bias_sel};
	assign d_mag    = d_val[24] ? 25'(-d_val) : 25'(d_val);
	assign r_sel    = rate_q[idx_q];
	assign r_mag    = r_sel[16] ? 17'(-r_sel) : 17'(r_sel);
	assign sum_sel  = sum_q[idx_q];
	assign s_mag    = sum_sel[24] ? 25'(-sum_sel) : 25'(sum_sel);

	// All roundings work on the magnitude and restore the sign afterwards.
	assign p_acc   = mul_p + 49'd2097152;
	assign acc_q14 = p_acc[35:22];
	assign p_rt    = mul_p + 49'd2147483648;
	assign rt_q17  = p_rt[48:32];
	assign p_inc   = mul_p + 49'd128;
	assign inc_mag = p_inc[33:8];

	always_comb begin
		// Rate saturates to the 17-bit signed range.
		if (d_val[24]) begin
			rt_val = (rt_q17 > 17'd65536) ? -17'sd65536 : 17'(-rt_q17);
		end else begin
			rt_val = (rt_q17 > 17'd65535) ? 17'sd65535 : 17'(rt_q17);
		end
		if (r_sel[16]) begin
			ang_sum = {{2{ang_q[idx_q][31]}}, ang_q[idx_q]} - {8'd0, inc_mag};
		end else begin
			ang_sum = {{2{ang_q[idx_q][31]}}, ang_q[idx_q]} + {8'd0, inc_mag};
		end
		if (ang_sum[33:31] == 3'b000 || ang_sum[33:31] == 3'b111) begin
			ang_new = ang_sum[31:0];
		end else begin
			ang_new = ang_sum[33] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sum_n[k] = {sum_q[k][24], sum_q[k]} + {{10{gyr_q[k][15]}}, gyr_q[k]};
			if (sum_n[k][25] != sum_n[k][24]) begin
				sum_sat[k] = sum_n[k][25] ? {1'b1, 24'd0} : {1'b0, {24{1'b1}}};
			end else begin
				sum_sat[k] = sum_n[k][24:0];
			end
		end
	end

	assign cnt_n   = cnt_q + imu_tilt_pkg::CNT_W'(1);
	assign rem_sh  = {rem_q, dvd_q[33]};
	assign rem_sub = rem_sh - {1'b0, DIV_N};
	assign q24     = quo_q[23:0];

	// The shared multiplier serves the accelerations, rates and angle steps.
	always_comb begin
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q)
			S_ACC: begin
				mul_start = 1'b1;
				mul_a     = 25'(acc_mag);
				mul_b     = imu_tilt_pkg::ACCEL_K;
			end
			S_RD: begin
				mul_start = 1'b1;
				mul_a     = d_mag;
				mul_b     = imu_tilt_pkg::RATE_K;
			end
			S_RI: begin
				mul_start = 1'b1;
				mul_a     = 25'(r_mag);
				mul_b     = 24'(step_q);
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	imu_tilt_smul #(.WA(25), .WB(24)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.p      (mul_p),
		.busy   (mul_busy)
	);

	imu_tilt_atan #(.CORDIC_STEPS(CORDIC_STEPS)) u_atan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (tilt_start),
		.ax     (accel_raw_x),
		.ay     (accel_raw_y),
		.az     (accel_raw_z),
		.roll   (tilt_roll),
		.pitch  (tilt_pitch),
		.busy   (tilt_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			func_q  <= 1'b0;
			step_q  <= 16'd655;
			mode_q  <= 1'b0;
			cnt_q   <= '0;
			dvd_q   <= '0;
			quo_q   <= '0;
			rem_q   <= '0;
			dcnt_q  <= '0;
			dneg_q  <= 1'b0;
			ov_q    <= 1'b0;
			o_roll_q  <= '0;
			o_pitch_q <= '0;
			o_cal_q   <= 1'b0;
			for (int k = 0; k < 3; k++) begin
				acc_q[k]    <= '0;
				gyr_q[k]    <= '0;
				sum_q[k]    <= '0;
				bias_q[k]   <= '0;
				rate_q[k]   <= '0;
				ang_q[k]    <= '0;
				accsi_q[k]  <= '0;
				o_acc_q[k]  <= '0;
				o_rate_q[k] <= '0;
				o_ang_q[k]  <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				step_q <= cfg_data;
			end
			// In the finishing step the result register is reloaded instead.
			if (ov_q && out_ready && state_q != S_FIN) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						func_q   <= func;
						acc_q[0] <= accel_raw_x;
						acc_q[1] <= accel_raw_y;
						acc_q[2] <= accel_raw_z;
						gyr_q[0] <= gyro_raw_x;
						gyr_q[1] <= gyro_raw_y;
						gyr_q[2] <= gyro_raw_z;
						idx_q    <= '0;
						state_q  <= S_ACC;
					end
				end
				S_ACC: begin
					state_q <= S_ACCW;
				end
				S_ACCW: begin
					if (!mul_busy) begin
						accsi_q[idx_q] <= acc_sel[15] ? 14'(-acc_q14) : acc_q14;
						if (idx_q != 2'd2) begin
							idx_q   <= idx_q + 2'd1;
							state_q <= S_ACC;
						end else if (func_q) begin
							// A start item restarts calibration from empty sums.
							mode_q <= 1'b1;
							cnt_q  <= '0;
							for (int k = 0; k < 3; k++) begin
								sum_q[k] <= '0;
							end
							state_q <= S_TW;
						end else if (mode_q) begin
							state_q <= S_CAL;
						end else begin
							idx_q   <= '0;
							state_q <= S_RD;
						end
					end
				end
				S_CAL: begin
					cnt_q <= cnt_n;
					for (int k = 0; k < 3; k++) begin
						sum_q[k] <= sum_sat[k];
					end
					if (cnt_n >= CNT_END) begin
						idx_q   <= '0;
						state_q <= S_DIVI;
					end else begin
						state_q <= S_TW;
					end
				end
				S_DIVI: begin
					dvd_q   <= {1'b0, s_mag, 8'd0} + DIV_HALF;
					dneg_q  <= sum_sel[24];
					rem_q   <= '0;
					quo_q   <= '0;
					dcnt_q  <= 6'd34;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (rem_sh >= {1'b0, DIV_N}) begin
						rem_q <= rem_sub[NW-1:0];
						quo_q <= {quo_q[32:0], 1'b1};
					end else begin
						rem_q <= rem_sh[NW-1:0];
						quo_q <= {quo_q[32:0], 1'b0};
					end
					dvd_q  <= dvd_q << 1;
					dcnt_q <= dcnt_q - 6'd1;
					if (dcnt_q == 6'd1) begin
						state_q <= S_DIVE;
					end
				end
				S_DIVE: begin
					bias_q[idx_q] <= dneg_q ? 24'(-q24) : q24;
					if (idx_q == 2'd2) begin
						mode_q  <= 1'b0;
						state_q <= S_TW;
					end else begin
						idx_q   <= idx_q + 2'd1;
						state_q <= S_DIVI;
					end
				end
				S_RD: begin
					state_q <= S_RDW;
				end
				S_RDW: begin
					if (!mul_busy) begin
						rate_q[idx_q] <= rt_val;
						state_q       <= S_RI;
					end
				end
				S_RI: begin
					state_q <= S_RIW;
				end
				S_RIW: begin
					if (!mul_busy) begin
						ang_q[idx_q] <= ang_new;
						if (idx_q == 2'd2) begin
							state_q <= S_TW;
						end else begin
							idx_q   <= idx_q + 2'd1;
							state_q <= S_RD;
						end
					end
				end
				S_TW: begin
					if (!tilt_busy) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					// The result register takes the item once it is free.
					if (!ov_q || out_ready) begin
						ov_q      <= 1'b1;
						o_roll_q  <= tilt_roll;
						o_pitch_q <= tilt_pitch;
						o_cal_q   <= mode_q;
						for (int k = 0; k < 3; k++) begin
							o_acc_q[k]  <= accsi_q[k];
							o_rate_q[k] <= rate_q[k];
							o_ang_q[k]  <= ang_q[k];
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = ov_q;
	assign roll_angle  = o_roll_q;
	assign pitch_angle = o_pitch_q;
	assign accel_x_si  = o_acc_q[0];
	assign accel_y_si  = o_acc_q[1];
	assign accel_z_si  = o_acc_q[2];
	assign rate_x      = o_rate_q[0];
	assign rate_y      = o_rate_q[1];
	assign rate_z      = o_rate_q[2];
	assign angle_x     = o_ang_q[0];
	assign angle_y     = o_ang_q[1];
	assign angle_z     = o_ang_q[2];
	assign calibrating = o_cal_q;

endmodule

/* rtl/imu_tilt_chk.sv */
// Port-level checks for the tilt and gyro integrator, bound to the top level.
// Depends on imu_tilt_gyro_integrator.
`timescale 1ns / 1ps

module imu_tilt_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               cfg_valid,
	input logic               cfg_ready,
	input logic [15:0]        cfg_data,
	input logic               in_valid,
	input logic               in_ready,
	input logic               func,
	input logic signed [15:0] accel_raw_x,
	input logic signed [15:0] accel_raw_y,
	input logic signed [15:0] accel_raw_z,
	input logic signed [15:0] gyro_raw_x,
	input logic signed [15:0] gyro_raw_y,
	input logic signed [15:0] gyro_raw_z,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] roll_angle,
	input logic signed [15:0] pitch_angle,
	input logic signed [13:0] accel_x_si,
	input logic signed [13:0] accel_y_si,
	input logic signed [13:0] accel_z_si,
	input logic signed [16:0] rate_x,
	input logic signed [16:0] rate_y,
	input logic signed [16:0] rate_z,
	input logic signed [31:0] angle_x,
	input logic signed [31:0] angle_y,
	input logic signed [31:0] angle_z,
	input logic               calibrating
);

	// One item at a time: after an input transfer the block is busy.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again straight after a transfer");

	// A new result appears only from the finishing step, not while idle.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without work in progress");

	// A stalled result holds: out_valid, angle_x, roll_angle and calibrating stay.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(angle_x) && $stable(roll_angle)
			&& $stable(calibrating))
		else $error("stalled result changed");

endmodule

bind imu_tilt_gyro_integrator imu_tilt_chk u_chk (.*);

/* tb/sv/testbench.sv */
// Self-checking testbench for imu_tilt_gyro_integrator: tilt, acceleration, rate and angle paths.
// Depends on the block's RTL and imu_tilt_pkg; a built-in predictor supplies the expected results.
`timescale 1ns / 1ps

module testbench;

	// One input transfer as offered to the block.
	typedef struct packed {
		logic        func;
		logic [15:0] ax, ay, az, gx, gy, gz;
	} sample_t;

	// One result transfer as predicted.
	typedef struct {
		logic [15:0] roll, pitch;
		logic [13:0] acx, acy, acz;
		logic [16:0] rx, ry, rz;
		logic [31:0] gax, gay, gaz;
		logic        cal;
	} imu_result_t;

	localparam int CAL_N = 500;
	localparam int LIMIT = 4000000;

	logic clk, arst_n;
	logic cfg_valid, cfg_ready;
	logic [15:0] cfg_data;
	logic in_valid, in_ready, func;
	logic signed [15:0] accel_raw_x, accel_raw_y, accel_raw_z;
	logic signed [15:0] gyro_raw_x, gyro_raw_y, gyro_raw_z;
	logic out_valid, out_ready;
	logic signed [15:0] roll_angle, pitch_angle;
	logic signed [13:0] accel_x_si, accel_y_si, accel_z_si;
	logic signed [16:0] rate_x, rate_y, rate_z;
	logic signed [31:0] angle_x, angle_y, angle_z;
	logic calibrating;

	imu_tilt_gyro_integrator dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .func(func),
		.accel_raw_x(accel_raw_x), .accel_raw_y(accel_raw_y), .accel_raw_z(accel_raw_z),
		.gyro_raw_x(gyro_raw_x), .gyro_raw_y(gyro_raw_y), .gyro_raw_z(gyro_raw_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.roll_angle(roll_angle), .pitch_angle(pitch_angle),
		.accel_x_si(accel_x_si), .accel_y_si(accel_y_si), .accel_z_si(accel_z_si),
		.rate_x(rate_x), .rate_y(rate_y), .rate_z(rate_z),
		.angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z),
		.calibrating(calibrating)
	);

	// Predictor state: a private copy of everything the block keeps.
	logic [15:0]  step_q16;
	logic         in_cal;
	int           cal_count;
	longint       sum_acc [3];
	longint       bias_q8 [3];
	longint       rate_keep [3];
	longint       angle_keep [3];

	sample_t      pending_samples [$];
	imu_result_t  awaited_results [$];
	int           errors;
	longint       cycle_count;

	// Phase control shared between the stimulus block, the driver and the receiver.
	bit           sender_hold;
	int           sink_hold;

	function automatic longint round_shift(longint v, int s);
		longint m;
		m = v < 0 ? -v : v;
		m = (m + (longint'(1) << (s - 1))) >>> s;
		return v < 0 ? -m : m;
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// Floor square root by the digit-by-digit method.
	function automatic longint floor_sqrt(longint n);
		longint res, bitv;
		res = 0;
		bitv = longint'(1) << 62;
		while (bitv > n)
			bitv = bitv >>> 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n = n - (res + bitv);
				res = (res >>> 1) + bitv;
			end else begin
				res = res >>> 1;
			end
			bitv = bitv >>> 2;
		end
		return res;
	endfunction

	// CORDIC vectoring of atan2(num, sqrt(a^2 + b^2)), result in 2^-13 rad.
	function automatic longint tilt_angle(longint num, longint a, longint b);
		longint x, y, z, xs, ys;
		x = floor_sqrt((a * a + b * b) << 16);
		y = num * 256;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		for (int i = 0; i < 16; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys; y -= xs; z += longint'(imu_tilt_pkg::atan_entry(5'(i)));
			end else begin
				x -= ys; y += xs; z -= longint'(imu_tilt_pkg::atan_entry(5'(i)));
			end
		end
		return round_shift(z, 3);
	endfunction

	function automatic void reset_model();
		step_q16 = 16'd655;
		in_cal = 1'b0;
		cal_count = 0;
		for (int k = 0; k < 3; k++) begin
			sum_acc[k] = 0; bias_q8[k] = 0; rate_keep[k] = 0; angle_keep[k] = 0;
		end
	endfunction

	// Advances the predictor by one sample and queues the result it implies.
	function automatic void predict_imu(sample_t s);
		longint ax, ay, az, d, r, q, m;
		longint g [3];
		imu_result_t e;
		ax = longint'($signed(s.ax)); ay = longint'($signed(s.ay));
		az = longint'($signed(s.az));
		g[0] = longint'($signed(s.gx)); g[1] = longint'($signed(s.gy));
		g[2] = longint'($signed(s.gz));
		if (s.func) begin
			in_cal = 1'b1;
			cal_count = 0;
			for (int k = 0; k < 3; k++) sum_acc[k] = 0;
		end else if (in_cal) begin
			cal_count = (cal_count + 1) & 10'h3FF;
			for (int k = 0; k < 3; k++)
				sum_acc[k] = clamp(sum_acc[k] + g[k], -16777216, 16777215);
			if (cal_count >= CAL_N) begin
				for (int k = 0; k < 3; k++) begin
					m = sum_acc[k] < 0 ? -sum_acc[k] : sum_acc[k];
					q = (m * 256 + CAL_N / 2) / CAL_N;
					bias_q8[k] = sum_acc[k] < 0 ? -q : q;
				end
				in_cal = 1'b0;
			end
		end else begin
			for (int k = 0; k < 3; k++) begin
				d = g[k] * 256 - bias_q8[k];
				r = clamp(round_shift(d * 9155581, 32), -65536, 65535);
				rate_keep[k] = r;
				angle_keep[k] = clamp(angle_keep[k] + round_shift(r * longint'(step_q16), 8),
					-64'sd2147483648, 64'sd2147483647);
			end
		end
		e.roll  = 16'(tilt_angle(ay, ax, az));
		e.pitch = 16'(tilt_angle(-ax, ay, az));
		e.acx = 14'(round_shift(ax * 642908, 22));
		e.acy = 14'(round_shift(ay * 642908, 22));
		e.acz = 14'(round_shift(az * 642908, 22));
		e.rx = 17'(rate_keep[0]); e.ry = 17'(rate_keep[1]); e.rz = 17'(rate_keep[2]);
		e.gax = 32'(angle_keep[0]); e.gay = 32'(angle_keep[1]); e.gaz = 32'(angle_keep[2]);
		e.cal = in_cal;
		awaited_results.push_back(e);
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
		errors++;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Driver: takes samples from the pending queue, with a random gap before each.
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
		end else if (in_valid && in_ready) begin
			// The transfer happened; the predictor sees it now.
			predict_imu({func, accel_raw_x, accel_raw_y, accel_raw_z,
				gyro_raw_x, gyro_raw_y, gyro_raw_z});
			in_valid <= 1'b0;
			gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 9);
		end else if (!in_valid && !sender_hold && pending_samples.size() != 0) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
			end else begin
				{func, accel_raw_x, accel_raw_y, accel_raw_z,
					gyro_raw_x, gyro_raw_y, gyro_raw_z} <= pending_samples.pop_front();
				in_valid <= 1'b1;
			end
		end
	end

	// Monitor and receiver: random stalls, plus a long hold-off when asked.
	int stall_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("unexpected result", 0, 0);
				end else begin
					imu_result_t e;
					e = awaited_results.pop_front();
					if (roll_angle !== e.roll)
						report_mismatch("roll_angle", roll_angle, $signed(e.roll));
					if (pitch_angle !== e.pitch)
						report_mismatch("pitch_angle", pitch_angle, $signed(e.pitch));
					if (accel_x_si !== e.acx) report_mismatch("accel_x_si", accel_x_si, $signed(e.acx));
					if (accel_y_si !== e.acy) report_mismatch("accel_y_si", accel_y_si, $signed(e.acy));
					if (accel_z_si !== e.acz) report_mismatch("accel_z_si", accel_z_si, $signed(e.acz));
					if (rate_x !== e.rx) report_mismatch("rate_x", rate_x, $signed(e.rx));
					if (rate_y !== e.ry) report_mismatch("rate_y", rate_y, $signed(e.ry));
					if (rate_z !== e.rz) report_mismatch("rate_z", rate_z, $signed(e.rz));
					if (angle_x !== e.gax) report_mismatch("angle_x", angle_x, $signed(e.gax));
					if (angle_y !== e.gay) report_mismatch("angle_y", angle_y, $signed(e.gay));
					if (angle_z !== e.gaz) report_mismatch("angle_z", angle_z, $signed(e.gaz));
					if (calibrating !== e.cal) report_mismatch("calibrating", calibrating, e.cal);
				end
			end
			if (sink_hold != 0) begin
				out_ready <= 1'b0;
			end else if (out_valid && out_ready || stall_left == 0 && !out_ready) begin
				// Draw a fresh stall for the next result; one in three has none.
				if ($urandom_range(0, 2) == 0) begin
					out_ready <= 1'b1;
					stall_left <= 0;
				end else begin
					out_ready <= 1'b0;
					stall_left <= $urandom_range(0, 9);
				end
			end else if (!out_ready) begin
				stall_left <= stall_left - 1;
			end
		end
	end

	// The long hold-off is counted here, in a process of its own.
	always @(posedge clk) begin
		if (sink_hold != 0)
			sink_hold <= sink_hold - 1;
	end

	// Random raw value, biased towards the extremes or small values now and then.
	function automatic logic [15:0] raw_value();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'(int'($urandom_range(0, 64)) - 32);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic sample_t random_sample(logic f);
		sample_t s;
		s.func = f;
		s.ax = raw_value(); s.ay = raw_value(); s.az = raw_value();
		s.gx = raw_value(); s.gy = raw_value(); s.gz = raw_value();
		return s;
	endfunction

	// A gyro sample near a realistic bias, so that calibrated rates stay moderate.
	function automatic sample_t steady_sample(int bias);
		sample_t s;
		s = random_sample(1'b0);
		s.gx = 16'(bias + int'($urandom_range(0, 40)) - 20);
		s.gy = 16'(-bias + int'($urandom_range(0, 40)) - 20);
		s.gz = 16'(int'($urandom_range(0, 200)) - 100);
		return s;
	endfunction

	// Waits until the queue is drained and every result is in, then a margin for the
	// slowest item, so that a register write lands on an idle block.
	task automatic wait_idle();
		while (pending_samples.size() != 0 || in_valid || awaited_results.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_step(logic [15:0] v);
		@(posedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		step_q16 = v;
		cfg_valid <= 1'b0;
	endtask

	initial begin
		sample_t s;
		errors = 0;
		cycle_count = 0;
		sender_hold = 1'b0;
		sink_hold = 0;
		reset_model();
		cfg_valid = 1'b0;
		cfg_data = '0;
		func = 1'b0;
		accel_raw_x = '0; accel_raw_y = '0; accel_raw_z = '0;
		gyro_raw_x = '0; gyro_raw_y = '0; gyro_raw_z = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero vector, each extreme on each axis, both operations.
		pending_samples.push_back('0);
		pending_samples.push_back({1'b0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000});
		pending_samples.push_back({1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF});
		pending_samples.push_back({1'b0, 16'h0000, 16'h0000, 16'h4000, 16'h0083, 16'hFF7D, 16'h0000});
		pending_samples.push_back({1'b0, 16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001});
		pending_samples.push_back({1'b0, 16'h0000, 16'hC000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000});
		pending_samples.push_back({1'b0, 16'h0000, 16'h0000, 16'hC000, 16'h0000, 16'h0000, 16'h0000});
		pending_samples.push_back({1'b0, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000});
		pending_samples.push_back({1'b0, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA});
		// A start item carries accelerations but its gyro fields are ignored.
		pending_samples.push_back({1'b1, 16'h1234, 16'hEDCB, 16'h4000, 16'h7FFF, 16'h8000, 16'h7FFF});
		// A start while calibrating restarts the count.
		pending_samples.push_back(random_sample(1'b0));
		pending_samples.push_back(random_sample(1'b1));
		wait_idle();

		// Full-scale gyro drives the sums to their largest reachable magnitudes.
		for (int i = 0; i < CAL_N; i++) begin
			s = random_sample(1'b0);
			s.gx = 16'h7FFF; s.gy = 16'h8000; s.gz = 16'($urandom);
			pending_samples.push_back(s);
		end
		// Now calibrated with a huge bias: rates reach their extremes, angles run to their rails.
		for (int i = 0; i < 100; i++) pending_samples.push_back(random_sample(1'b0));
		wait_idle();
		write_step(16'hFFFF);
		for (int i = 0; i < 250; i++) pending_samples.push_back(random_sample(1'b0));
		wait_idle();

		// Zero step time: angles must stand still.
		write_step(16'h0000);
		for (int i = 0; i < 20; i++) pending_samples.push_back(random_sample(1'b0));
		wait_idle();

		// Realistic calibration followed by small rates, with the smallest step.
		write_step(16'h0001);
		pending_samples.push_back(random_sample(1'b1));
		for (int i = 0; i < CAL_N; i++) pending_samples.push_back(steady_sample(37));
		for (int i = 0; i < 60; i++) pending_samples.push_back(steady_sample(37));
		// Keep the receiver off for a long while so the block backs up its input.
		while (awaited_results.size() == 0) @(posedge clk);
		sink_hold = 3000;
		wait_idle();

		write_step(16'd655);
		// Sender pause until the block has delivered everything, then a noisy tail.
		sender_hold = 1'b1;
		wait_idle();
		sender_hold = 1'b0;
		for (int i = 0; i < 300; i++)
			pending_samples.push_back(random_sample($urandom_range(0, 49) == 0));
		wait_idle();
		write_step(16'($urandom_range(1, 65535)));
		for (int i = 0; i < 40; i++) pending_samples.push_back(random_sample(1'b0));
		wait_idle();

		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/imu_tilt_pkg.sv
rtl/imu_tilt_smul.sv
rtl/imu_tilt_atan.sv
rtl/imu_tilt_gyro_integrator.sv
rtl/imu_tilt_chk.sv
tb/sv/testbench.sv
